### hdl/binary_to_decimal_ascii_defines.svh
// Assertion macros used by the binary-to-decimal converter top level.
`ifndef BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define B2DA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("binary_to_decimal_ascii: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define B2DA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("binary_to_decimal_ascii: next-cycle check failed");

`endif

### hdl/b2da_pkg.sv
// Types, constants and the double-dabble step shared by the converter files.
package b2da_pkg;

	localparam int NUM_DIGITS = 10;
	localparam int BCD_W = 4 * NUM_DIGITS;
	localparam int VALUE_W = 32;
	localparam int STAGE_BITS = 8;
	localparam int NUM_STAGES = VALUE_W / STAGE_BITS;

	localparam logic [5:0] DIGIT_BASE = 6'h30;
	localparam logic [5:0] DIGIT_MAX = 6'd57;
	localparam logic [3:0] LAST_POS = 4'd9;

	typedef logic [BCD_W-1:0] bcd_t;
	typedef logic [VALUE_W-1:0] value_t;
	typedef logic [3:0] digit_t;

	// One shift-add-3 step: correct every digit of five or more, then shift in one bit.
	function automatic bcd_t dd_step(input bcd_t bcd, input logic in_bit);
		bcd_t adj;
		digit_t nib;
		adj = bcd;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			nib = bcd[4*i +: 4];
			if (nib >= 4'd5) begin
				nib = nib + 4'd3;
			end
			adj[4*i +: 4] = nib;
		end
		return {adj[BCD_W-2:0], in_bit};
	endfunction

endpackage

### hdl/b2da_stage.sv
// One pipeline stage of the converter: eight double-dabble steps and their register.
module b2da_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            in_vld,
	input  b2da_pkg::bcd_t  in_bcd,
	input  b2da_pkg::value_t in_bits,
	output logic            out_vld,
	output b2da_pkg::bcd_t  out_bcd,
	output b2da_pkg::value_t out_bits
);

	b2da_pkg::bcd_t  bcd_nxt;
	b2da_pkg::value_t bits_nxt;

	// Consume the top eight remaining bits, most significant first.
	always_comb begin
		bcd_nxt = in_bcd;
		for (int i = 0; i < b2da_pkg::STAGE_BITS; i++) begin
			bcd_nxt = b2da_pkg::dd_step(bcd_nxt, in_bits[b2da_pkg::VALUE_W-1-i]);
		end
		bits_nxt = {in_bits[b2da_pkg::VALUE_W-b2da_pkg::STAGE_BITS-1:0],
			{b2da_pkg::STAGE_BITS{1'b0}}};
	end

	// The valid bit moves whenever the stage advances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (adv) begin
			out_vld <= in_vld;
		end
	end

	// Payload is captured only for a valid item.
	always_ff @(posedge clk) begin
		if (adv && in_vld) begin
			out_bcd  <= bcd_nxt;
			out_bits <= bits_nxt;
		end
	end

endmodule

### hdl/binary_to_decimal_ascii.sv
// The first digit is offered once an item has passed the stage registers and the serializer; five items fit inside.
// Four double-dabble stages of eight input bits each feed a digit serializer.
// The serializer emits one digit per cycle while dst_stall is low and loads the next item
// in the same cycle that the last digit of the current one is taken.
// Reset: arst_n clears all valid bits and the serializer asynchronously; data is not reset.
// Top level of the 32-bit binary to decimal ASCII converter.
`include "binary_to_decimal_ascii_defines.svh"

module binary_to_decimal_ascii (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       src_valid,
	output logic       src_stall,
	input  logic [31:0] value,
	output logic       dst_valid,
	input  logic       dst_stall,
	output logic [5:0] digit_char,
	output logic [3:0] position,
	output logic       last
);

	localparam int NS = b2da_pkg::NUM_STAGES;

	logic             vld [0:NS];
	b2da_pkg::bcd_t   bcd [0:NS];
	b2da_pkg::value_t bits [0:NS];
	logic             adv [0:NS];

	logic           busy_q;
	b2da_pkg::bcd_t bcd_q;
	logic [3:0]     idx_q;
	logic [3:0]     top_idx;
	logic           load;
	b2da_pkg::digit_t cur;

	// Pipeline entry: a fresh item starts with an empty BCD field.
	assign vld[0]  = src_valid;
	assign bcd[0]  = '0;
	assign bits[0] = value;

	// Serializer takes a new item when idle or when its last digit leaves now.
	assign load = !busy_q || (!dst_stall && (idx_q == 4'd0));

	// Each stage moves when it is empty or its successor moves.
	assign adv[NS] = load;
	for (genvar k = 0; k < NS; k++) begin : g_adv
		assign adv[k] = !vld[k+1] || adv[k+1];
	end
	assign src_stall = !adv[0];

	for (genvar k = 0; k < NS; k++) begin : g_stage
		b2da_stage u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv[k]),
			.in_vld  (vld[k]),
			.in_bcd  (bcd[k]),
			.in_bits (bits[k]),
			.out_vld (vld[k+1]),
			.out_bcd (bcd[k+1]),
			.out_bits(bits[k+1])
		);
	end

	// Index of the most significant nonzero digit, zero when the value is zero.
	always_comb begin
		top_idx = 4'd0;
		for (int i = 1; i < b2da_pkg::NUM_DIGITS; i++) begin
			if (bcd[NS][4*i +: 4] != 4'd0) begin
				top_idx = 4'(i);
			end
		end
	end

	// Serializer control: walk from the top digit down to the units digit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 4'd0;
		end else if (load) begin
			busy_q <= vld[NS];
			idx_q  <= top_idx;
		end else if (!dst_stall) begin
			idx_q <= idx_q - 4'd1;
		end
	end

	// Serializer digits are captured with each new item.
	always_ff @(posedge clk) begin
		if (load && vld[NS]) begin
			bcd_q <= bcd[NS];
		end
	end

	// Output item from the held digits.
	assign cur        = bcd_q[{idx_q, 2'b00} +: 4];
	assign dst_valid  = busy_q;
	assign digit_char = b2da_pkg::DIGIT_BASE + {2'b00, cur};
	assign position   = b2da_pkg::LAST_POS - idx_q;
	assign last       = (idx_q == 4'd0);

	// Every emitted character is a decimal digit.
	`B2DA_ASSERT_NOW(a_digit_range, busy_q, digit_char <= b2da_pkg::DIGIT_MAX)
	// A taken non-final digit is followed by the next lower digit of the same item.
	`B2DA_ASSERT_NEXT(a_walk_down, busy_q && !dst_stall && (idx_q != 4'd0), busy_q && (idx_q == $past(idx_q) - 4'd1))
	// A stalled output keeps its place.
	`B2DA_ASSERT_NEXT(a_hold_on_stall, busy_q && dst_stall, busy_q && $stable(position) && $stable(digit_char))
	// An item in the last stage that cannot move is still there next cycle.
	`B2DA_ASSERT_NEXT(a_stage_hold, vld[NS] && !load, vld[NS])

endmodule
